// ----- rtl/plcd_pkg.sv -----
// Shared types and constants for the polyline line crossing detector.
`default_nettype none

package plcd_pkg;

    // Arc positions are unsigned Q21.10 values of this many bits.
    localparam int S_BITS     = 31;
    localparam int S_CNT_BITS = $clog2(S_BITS);

    // Configuration register indexes.
    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LINE_START_X = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LINE_START_Y = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LINE_END_X   = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LINE_END_Y   = 2'd3;

    // Control of the bit-serial multiplier lanes.
    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } t_mul_ctrl;

endpackage

`default_nettype wire

// ----- rtl/polyline_line_crossing_detector.sv -----
// Top level of the polyline line crossing detector.
// Usage: trajectory samples (arc position, x, y, new-trajectory flag) come in
// on the sample channel (i_sample_valid / o_sample_stall); each accepted beat
// tests the step from the previous sample to this one against the line held
// in the four configuration registers (i_cfg_we / i_cfg_addr / i_cfg_data).
// A crossing yields one beat on the crossing channel (o_crossing_valid /
// i_crossing_stall); a parallel step, a miss or a first sample yields none.
// A first sample is stored without a test and leaves the block idle. A tested
// sample runs six bit-serial multiplier lanes, then forms and checks the
// determinant and numerators; a parallel step or a miss frees the block there.
// A crossing then goes through the offset unit (shift-add, then restoring
// division); its result enters the output register before the next sample.
// One sample is processed at a time; o_sample_stall is high while it runs.
// A finished result sits in the output register until taken; if that register
// is still occupied when the next result is ready, the block waits for it.
// Reset clears the configuration registers to zero, forgets the previous
// sample and empties the output register.
`default_nettype none

module polyline_line_crossing_detector
    import plcd_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire [CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  wire [COORD_BITS-1:0]     i_cfg_data,
    input  wire                      i_sample_valid,
    output logic                     o_sample_stall,
    input  wire [S_BITS-1:0]         i_sample_s,
    input  wire [COORD_BITS-1:0]     i_sample_x,
    input  wire [COORD_BITS-1:0]     i_sample_y,
    input  wire                      i_new_trajectory,
    output logic                     o_crossing_valid,
    input  wire                      i_crossing_stall,
    output logic [S_BITS-1:0]        o_crossing_s
);

    localparam int DW       = COORD_BITS + 1;
    localparam int PW       = 2 * COORD_BITS + 2;
    localparam int CNT_BITS = $clog2(DW);
    localparam int NLANE    = 6;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_CROSS = 3'd2;
    localparam logic [2:0] ST_NORM  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]            r_state;
    logic [CNT_BITS-1:0]   r_cnt;

    logic [COORD_BITS-1:0] r_line_sx;
    logic [COORD_BITS-1:0] r_line_sy;
    logic [COORD_BITS-1:0] r_line_ex;
    logic [COORD_BITS-1:0] r_line_ey;

    logic [S_BITS-1:0]     r_prev_s;
    logic [COORD_BITS-1:0] r_prev_x;
    logic [COORD_BITS-1:0] r_prev_y;
    logic                  r_prev_valid;

    logic [S_BITS-1:0]     r_base_s;
    logic [S_BITS-1:0]     r_mag;
    logic                  r_down;

    logic signed [PW-1:0]  r_det;
    logic signed [PW-1:0]  r_nt;
    logic signed [PW-1:0]  r_nu;

    logic [S_BITS-1:0]     r_out_s;
    logic                  r_out_valid;

    logic                  w_accept;
    logic                  w_test;
    logic                  w_out_free;
    logic                  w_in_range;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [S_BITS-1:0]     w_quot;
    logic [S_BITS-1:0]     w_result;
    logic                  w_s_down;
    logic [S_BITS-1:0]     w_mag;
    t_mul_ctrl             w_mul_ctrl;

    logic signed [DW-1:0]  w_dx;
    logic signed [DW-1:0]  w_dy;
    logic signed [DW-1:0]  w_lx;
    logic signed [DW-1:0]  w_ly;
    logic signed [DW-1:0]  w_wx;
    logic signed [DW-1:0]  w_wy;

    logic signed [DW-1:0]  w_mcand  [NLANE];
    logic [DW-1:0]         w_mplier [NLANE];
    logic [PW-1:0]         w_prod   [NLANE];

    assign o_sample_stall = (r_state != ST_IDLE);
    assign w_accept       = i_sample_valid && !o_sample_stall;
    assign w_test         = !i_new_trajectory && r_prev_valid;
    assign w_out_free     = !r_out_valid || !i_crossing_stall;

    // Step and line vectors, all exact at one bit wider than a coordinate.
    assign w_dx = {i_sample_x[COORD_BITS-1], i_sample_x} - {r_prev_x[COORD_BITS-1], r_prev_x};
    assign w_dy = {i_sample_y[COORD_BITS-1], i_sample_y} - {r_prev_y[COORD_BITS-1], r_prev_y};
    assign w_lx = {r_line_ex[COORD_BITS-1], r_line_ex} - {r_line_sx[COORD_BITS-1], r_line_sx};
    assign w_ly = {r_line_ey[COORD_BITS-1], r_line_ey} - {r_line_sy[COORD_BITS-1], r_line_sy};
    assign w_wx = {r_line_sx[COORD_BITS-1], r_line_sx} - {r_prev_x[COORD_BITS-1], r_prev_x};
    assign w_wy = {r_line_sy[COORD_BITS-1], r_line_sy} - {r_prev_y[COORD_BITS-1], r_prev_y};

    assign w_s_down = (i_sample_s < r_prev_s);
    assign w_mag    = w_s_down ? (r_prev_s - i_sample_s) : (i_sample_s - r_prev_s);

    // det = dx*ly - dy*lx, nt = wx*ly - wy*lx, nu = wx*dy - wy*dx
    assign w_mcand[0] = w_ly;  assign w_mplier[0] = w_dx;
    assign w_mcand[1] = w_lx;  assign w_mplier[1] = w_dy;
    assign w_mcand[2] = w_ly;  assign w_mplier[2] = w_wx;
    assign w_mcand[3] = w_lx;  assign w_mplier[3] = w_wy;
    assign w_mcand[4] = w_dy;  assign w_mplier[4] = w_wx;
    assign w_mcand[5] = w_dx;  assign w_mplier[5] = w_wy;

    assign w_mul_ctrl.load = w_accept;
    assign w_mul_ctrl.step = (r_state == ST_MUL);
    assign w_mul_ctrl.last = (r_cnt == CNT_BITS'(COORD_BITS));

    for (genvar g = 0; g < NLANE; g++) begin : g_lane
        plcd_serial_mul #(
            .B (DW),
            .W (PW)
        ) u_mul (
            .i_clk    (i_clk),
            .i_ctrl   (w_mul_ctrl),
            .i_mcand  (w_mcand[g]),
            .i_mplier (w_mplier[g]),
            .o_prod   (w_prod[g])
        );
    end

    // After normalization det is positive; t and u are in [0,1] exactly
    // when both numerators lie between zero and det inclusive.
    assign w_in_range  = !r_nt[PW-1] && !r_nu[PW-1] && (r_nt <= r_det) && (r_nu <= r_det);
    assign w_div_start = (r_state == ST_CHECK) && w_in_range;

    plcd_divider #(
        .W (PW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_mag   (r_mag),
        .i_nt    (r_nt),
        .i_det   (r_det),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_result = r_down ? (r_base_s - w_quot) : (r_base_s + w_quot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_sx <= '0;
            r_line_sy <= '0;
            r_line_ex <= '0;
            r_line_ey <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_LINE_START_X: r_line_sx <= i_cfg_data;
                CFG_LINE_START_Y: r_line_sy <= i_cfg_data;
                CFG_LINE_END_X:   r_line_ex <= i_cfg_data;
                CFG_LINE_END_Y:   r_line_ey <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_s     <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_prev_valid <= 1'b0;
        end else if (w_accept) begin
            r_prev_s     <= i_sample_s;
            r_prev_x     <= i_sample_x;
            r_prev_y     <= i_sample_y;
            r_prev_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base_s <= r_prev_s;
            r_mag    <= w_mag;
            r_down   <= w_s_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CROSS) begin
            r_det <= w_prod[0] - w_prod[1];
            r_nt  <= w_prod[2] - w_prod[3];
            r_nu  <= w_prod[4] - w_prod[5];
        end else if ((r_state == ST_NORM) && r_det[PW-1]) begin
            r_det <= -r_det;
            r_nt  <= -r_nt;
            r_nu  <= -r_nu;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && w_test) begin
                        r_state <= ST_MUL;
                        r_cnt   <= '0;
                    end
                end
                ST_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_mul_ctrl.last) begin
                        r_state <= ST_CROSS;
                    end
                end
                ST_CROSS: begin
                    r_state <= ST_NORM;
                end
                ST_NORM: begin
                    r_state <= (r_det == '0) ? ST_IDLE : ST_CHECK;
                end
                ST_CHECK: begin
                    r_state <= w_in_range ? ST_DIV : ST_IDLE;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_crossing_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            r_out_s <= w_result;
        end
    end

    assign o_crossing_valid = r_out_valid;
    assign o_crossing_s     = r_out_s;

endmodule

`default_nettype wire

// ----- rtl/plcd_serial_mul.sv -----
// Bit-serial signed shift-add multiplier lane, one multiplier bit per cycle.
`default_nettype none

module plcd_serial_mul
    import plcd_pkg::*;
#(
    parameter int B = 33,
    parameter int W = 66
) (
    input  wire                  i_clk,
    input  wire t_mul_ctrl       i_ctrl,
    input  wire logic signed [B-1:0] i_mcand,
    input  wire logic [B-1:0]    i_mplier,
    output logic [W-1:0]         o_prod
);

    logic [W-1:0] r_acc;
    logic [W-1:0] r_mcand;
    logic [B-1:0] r_mplier;
    logic [W-1:0] w_addend;
    logic [W-1:0] w_sum;

    // The top multiplier bit carries negative weight, so it is subtracted.
    always_comb begin
        w_addend = r_mplier[0] ? r_mcand : '0;
        w_sum    = i_ctrl.last ? (r_acc - w_addend) : (r_acc + w_addend);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_acc    <= '0;
            r_mcand  <= W'(i_mcand);
            r_mplier <= i_mplier;
        end else if (i_ctrl.step) begin
            r_acc    <= w_sum;
            r_mcand  <= {r_mcand[W-2:0], 1'b0};
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ----- rtl/plcd_divider.sv -----
// Serial offset unit: forms mag*nt one bit a cycle, then divides by det one quotient bit a cycle.
`default_nettype none

module plcd_divider
    import plcd_pkg::*;
#(
    parameter int W = 66
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire [S_BITS-1:0]   i_mag,
    input  wire [W-1:0]        i_nt,
    input  wire [W-1:0]        i_det,
    output logic               o_done,
    output logic [S_BITS-1:0]  o_quot
);

    localparam int PW = W + S_BITS;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_MUL  = 2'd1;
    localparam logic [1:0] D_DIV  = 2'd2;
    localparam logic [1:0] D_DONE = 2'd3;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [S_CNT_BITS-1:0] r_cnt;
    logic [S_CNT_BITS-1:0] n_cnt;
    logic [PW-1:0]         r_prod;
    logic [PW-1:0]         n_prod;
    logic [S_BITS-1:0]     r_mag;
    logic [S_BITS-1:0]     n_mag;

    logic [PW-1:0] w_mul_next;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;
    logic          w_ge;
    logic [W-1:0]  w_rem;
    logic [PW-1:0] w_div_next;
    logic          w_last;

    // nt and det are held steady by the caller for the whole run. Since
    // nt <= det and mag < 2^S_BITS, the upper part of the product is already
    // below det, so plain restoring division over the low bits is exact.
    always_comb begin
        w_mul_next = {r_prod[PW-2:0], 1'b0} + (r_mag[S_BITS-1] ? PW'(i_nt) : '0);
        w_trial    = {r_prod[PW-1:S_BITS], r_prod[S_BITS-1]};
        w_diff     = w_trial - {1'b0, i_det};
        w_ge       = !w_diff[W];
        w_rem      = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
        w_div_next = {w_rem, r_prod[S_BITS-2:0], w_ge};
        w_last     = (r_cnt == S_CNT_BITS'(S_BITS - 1));
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_prod  = r_prod;
        n_mag   = r_mag;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_state = D_MUL;
                    n_cnt   = '0;
                    n_prod  = '0;
                    n_mag   = i_mag;
                end
            end
            D_MUL: begin
                n_prod = w_mul_next;
                n_mag  = r_mag << 1;
                n_cnt  = r_cnt + 1'b1;
                if (w_last) begin
                    n_cnt   = '0;
                    n_state = D_DIV;
                end
            end
            D_DIV: begin
                n_prod = w_div_next;
                n_cnt  = r_cnt + 1'b1;
                if (w_last) begin
                    n_cnt   = '0;
                    n_state = D_DONE;
                end
            end
            D_DONE: begin
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_prod <= n_prod;
        r_mag  <= n_mag;
    end

    assign o_done = (r_state == D_DONE);
    assign o_quot = r_prod[S_BITS-1:0];

endmodule

`default_nettype wire

// ----- bench/polyline_line_crossing_detector_tb.sv -----
// Self-checking testbench for the polyline line crossing detector.
`timescale 1ns / 100ps

module polyline_line_crossing_detector_tb
    import plcd_pkg::*;
();

    localparam logic signed [31:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic signed [31:0] C_MIN = 32'h8000_0000;
    localparam int FIFO_DEPTH = 64;

    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_AT} t_exp_kind;
    typedef enum logic {ROW_SAMPLE, ROW_LINE} t_row_op;

    // For a sample row: a = arc position, b = x, c = y, d[0] = new trajectory.
    // For a line row: a, b = start point, c, d = end point.
    typedef struct packed {
        t_row_op     op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        t_exp_kind   kind;
        logic [30:0] at;
    } t_plan_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr;
    logic [31:0]              i_cfg_data;
    logic                     i_sample_valid;
    logic                     o_sample_stall;
    logic [S_BITS-1:0]        i_sample_s;
    logic [31:0]              i_sample_x;
    logic [31:0]              i_sample_y;
    logic                     i_new_trajectory;
    logic                     o_crossing_valid;
    logic                     i_crossing_stall = 1'b0;
    logic [S_BITS-1:0]        o_crossing_s;

    // Line registers and previous sample as the block should hold them.
    logic signed [31:0] line_reg [4];
    logic [30:0]        prev_s;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic               have_prev;

    // Expected crossing beats, in order, as a ring of write and read counts.
    logic [30:0] crossing_fifo [FIFO_DEPTH];
    int          fifo_wr = 0;
    int          fifo_rd = 0;
    int          bad_beats = 0;
    bit          tx_rush = 1'b0;
    bit          rx_rush = 1'b0;
    int          rx_wait = 0;
    int          rx_taken = 0;

    t_plan_row plan [24] = '{
        // After reset the line is a single point, so nothing can cross it.
        '{ROW_SAMPLE, 32'd0, -32'sd1024, 32'd0, 32'd0, EXP_NONE, 31'd0},
        '{ROW_SAMPLE, 32'd2048, 32'd1024, 32'd0, 32'd0, EXP_NONE, 31'd0},
        '{ROW_LINE, 32'd0, -32'sd4096, 32'd0, 32'd4096, EXP_NONE, 31'd0},
        '{ROW_SAMPLE, 32'd0, -32'sd1024, 32'd0, 32'd1, EXP_NONE, 31'd0},
        '{ROW_SAMPLE, 32'd2048, 32'd1024, 32'd0, 32'd0, EXP_AT, 31'd1024},
        '{ROW_SAMPLE, 32'd4096, 32'd1024, 32'd5000, 32'd0, EXP_NONE, 31'd0},
        '{ROW_SAMPLE, 32'd4096, 32'd1024, 32'd5000, 32'd0, EXP_NONE, 31'd0},
        '{ROW_SAMPLE, 32'd100, 32'd0, 32'd0, 32'd1, EXP_NONE, 31'd0},
        '{ROW_SAMPLE, 32'd300, 32'd2048, 32'd0, 32'd0, EXP_AT, 31'd100},
        '{ROW_SAMPLE, 32'd500, 32'd0, 32'd0, 32'd0, EXP_AT, 31'd500},
        '{ROW_SAMPLE, 32'd0, -32'sd1024, 32'd4096, 32'd1, EXP_NONE, 31'd0},
        '{ROW_SAMPLE, 32'd1000, 32'd1024, 32'd4096, 32'd0, EXP_AT, 31'd500},
        '{ROW_SAMPLE, 32'd2000, -32'sd1024, 32'd4097, 32'd0, EXP_NONE, 31'd0},
        '{ROW_SAMPLE, 32'd3000, -32'sd1024, 32'd0, 32'd1, EXP_NONE, 31'd0},
        '{ROW_SAMPLE, 32'd1000, 32'd3072, 32'd0, 32'd0, EXP_AT, 31'd2500},
        '{ROW_SAMPLE, 32'd0, -32'sd1, 32'd0, 32'd1, EXP_NONE, 31'd0},
        '{ROW_SAMPLE, 32'd7, 32'd2, 32'd0, 32'd0, EXP_MODEL, 31'd0},
        '{ROW_SAMPLE, 32'd0, -32'sd1, 32'd0, 32'd0, EXP_MODEL, 31'd0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0, EXP_MODEL, 31'd0},
        '{ROW_SAMPLE, 32'd0, -32'sd1, 32'd0, 32'd0, EXP_MODEL, 31'd0},
        '{ROW_LINE, C_MIN, C_MIN, C_MAX, C_MAX, EXP_NONE, 31'd0},
        '{ROW_SAMPLE, 32'd0, C_MIN, C_MAX, 32'd1, EXP_NONE, 31'd0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, C_MAX, C_MIN, 32'd0, EXP_MODEL, 31'd0},
        '{ROW_SAMPLE, 32'd12345, C_MIN, C_MIN, 32'd0, EXP_MODEL, 31'd0}
    };

    polyline_line_crossing_detector #(
        .COORD_BITS(32)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_sample_valid  (i_sample_valid),
        .o_sample_stall  (o_sample_stall),
        .i_sample_s      (i_sample_s),
        .i_sample_x      (i_sample_x),
        .i_sample_y      (i_sample_y),
        .i_new_trajectory(i_new_trajectory),
        .o_crossing_valid(o_crossing_valid),
        .i_crossing_stall(i_crossing_stall),
        .o_crossing_s    (o_crossing_s)
    );

    function automatic int idle_cycles(input bit rush);
        return rush ? 0 : int'($urandom_range(14, 0));
    endfunction

    function automatic logic signed [31:0] rand_coord(input int bits);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> (32 - bits);
    endfunction

    // Exact segment test: t and u are compared as fractions of the determinant,
    // and the arc offset is |ds| * t truncated toward zero.
    function automatic logic predict_crossing(input logic [30:0] s,
                                              input logic signed [31:0] x, y,
                                              input logic fresh,
                                              output logic [30:0] at);
        logic signed [127:0] lx, ly, dx, dy, wx, wy, det, num_t, num_u;
        logic [127:0]        mag, q;
        logic                hit;
        hit = 1'b0;
        at = '0;
        if (!fresh && have_prev) begin
            lx = line_reg[CFG_LINE_END_X] - line_reg[CFG_LINE_START_X];
            ly = line_reg[CFG_LINE_END_Y] - line_reg[CFG_LINE_START_Y];
            dx = x - prev_x;
            dy = y - prev_y;
            wx = line_reg[CFG_LINE_START_X] - prev_x;
            wy = line_reg[CFG_LINE_START_Y] - prev_y;
            det = dx * ly - dy * lx;
            num_t = wx * ly - wy * lx;
            num_u = wx * dy - wy * dx;
            if (det != 0) begin
                if (det < 0) begin
                    det = -det;
                    num_t = -num_t;
                    num_u = -num_u;
                end
                if (num_t >= 0 && num_t <= det && num_u >= 0 && num_u <= det) begin
                    mag = (s < prev_s) ? prev_s - s : s - prev_s;
                    q = (mag * $unsigned(num_t)) / $unsigned(det);
                    at = (s < prev_s) ? prev_s - q[30:0] : prev_s + q[30:0];
                    hit = 1'b1;
                end
            end
        end
        prev_s = s;
        prev_x = x;
        prev_y = y;
        have_prev = 1'b1;
        return hit;
    endfunction

    task automatic queue_beat(input logic [30:0] v);
        crossing_fifo[fifo_wr % FIFO_DEPTH] = v;
        fifo_wr++;
    endtask

    task automatic push_sample(input logic [30:0] s, input logic signed [31:0] x, y,
                               input logic fresh, input t_exp_kind kind,
                               input logic [30:0] typed_at);
        int          gap;
        logic        hit;
        logic [30:0] at;
        gap = idle_cycles(tx_rush);
        if (gap > 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample_valid   <= 1'b1;
        i_sample_s       <= s;
        i_sample_x       <= x;
        i_sample_y       <= y;
        i_new_trajectory <= fresh;
        do @(posedge i_clk); while (o_sample_stall);
        hit = predict_crossing(s, x, y, fresh, at);
        if (kind == EXP_AT) begin
            queue_beat(typed_at);
        end else if (kind == EXP_MODEL && hit) begin
            queue_beat(at);
        end
    endtask

    // A missed sample leaves no beat behind, so give the block its full
    // crossing latency after the last expected beat before touching it.
    task automatic drain_results();
        i_sample_valid <= 1'b0;
        while (fifo_wr != fifo_rd) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic signed [31:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        line_reg[idx] = v;
    endtask

    task automatic load_line(input logic signed [31:0] sx, sy, ex, ey);
        drain_results();
        put_reg(CFG_LINE_START_X, sx);
        put_reg(CFG_LINE_START_Y, sy);
        put_reg(CFG_LINE_END_X, ex);
        put_reg(CFG_LINE_END_Y, ey);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin : crossing_sink
        logic [30:0] want;
        if (i_rst_n) begin
            if (o_crossing_valid && !i_crossing_stall) begin
                if (fifo_wr == fifo_rd) begin
                    $display("%0t ns: crossing_s expected no beat, got %0d", $time,
                             o_crossing_s);
                    bad_beats++;
                end else begin
                    want = crossing_fifo[fifo_rd % FIFO_DEPTH];
                    fifo_rd++;
                    if (o_crossing_s !== want) begin
                        $display("%0t ns: crossing_s expected %0d, got %0d", $time, want,
                                 o_crossing_s);
                        bad_beats++;
                    end
                end
                rx_wait = idle_cycles(rx_rush);
                rx_taken++;
                if (rx_taken % 16 == 0) rx_rush = ($urandom_range(2, 0) == 0);
            end else if (o_crossing_valid && rx_wait > 0) begin
                rx_wait--;
            end
            i_crossing_stall <= (rx_wait != 0);
        end
    end

    initial begin
        int                 sent;
        int                 bits;
        int                 phase_len;
        int                 left_in_traj;
        logic signed [31:0] sx, sy, ex, ey, px, py;
        logic [30:0]        run_s;
        logic               fresh;
        logic [31:0]        corners;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_addr       = CFG_LINE_START_X;
        i_cfg_data       = '0;
        i_sample_valid   = 1'b0;
        i_sample_s       = '0;
        i_sample_x       = '0;
        i_sample_y       = '0;
        i_new_trajectory = 1'b0;
        foreach (line_reg[k]) line_reg[k] = '0;
        prev_s    = '0;
        prev_x    = '0;
        prev_y    = '0;
        have_prev = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].op == ROW_LINE) begin
                load_line(plan[r].a, plan[r].b, plan[r].c, plan[r].d);
            end else begin
                push_sample(plan[r].a[30:0], plan[r].b, plan[r].c, plan[r].d[0],
                            plan[r].kind, plan[r].at);
            end
        end

        // Random phases: a new line each time, then trajectories near it.
        sent = 0;
        px = '0;
        py = '0;
        run_s = '0;
        while (sent < 1330) begin
            case ($urandom_range(4, 0))
                0: bits = 4;
                1: bits = 12;
                2: bits = 20;
                3: bits = 28;
                default: bits = 32;
            endcase
            sx = rand_coord(bits);
            sy = rand_coord(bits);
            ex = rand_coord(bits);
            ey = rand_coord(bits);
            case ($urandom_range(5, 0))
                3: begin
                    ex = sx;
                    ey = sy;
                end
                4: begin
                    if ($urandom_range(1, 0)) ex = sx;
                    else ey = sy;
                end
                5: begin
                    corners = $urandom;
                    sx = corners[0] ? C_MAX : C_MIN;
                    sy = corners[1] ? C_MAX : C_MIN;
                    ex = corners[2] ? C_MAX : C_MIN;
                    ey = corners[3] ? C_MAX : C_MIN;
                end
                default: ;
            endcase
            load_line(sx, sy, ex, ey);

            phase_len = $urandom_range(120, 40);
            left_in_traj = 0;
            repeat (phase_len) begin
                fresh = 1'b0;
                if (left_in_traj == 0) begin
                    left_in_traj = $urandom_range(25, 3);
                    fresh = 1'b1;
                    tx_rush = ($urandom_range(3, 0) == 0);
                    run_s = 31'($urandom);
                end else if ($urandom_range(31, 0) == 0) begin
                    fresh = 1'b1;
                end
                left_in_traj--;

                case ($urandom_range(15, 0))
                    0: ;  // repeat the previous point: zero-length step
                    1: begin
                        px = px + (ex - sx);
                        py = py + (ey - sy);
                    end
                    2: begin
                        px = sx;
                        py = sy;
                    end
                    3: begin
                        px = ex;
                        py = ey;
                    end
                    4: begin
                        px = $urandom;
                        py = $urandom;
                    end
                    default: begin
                        px = rand_coord(bits);
                        py = rand_coord(bits);
                    end
                endcase

                case ($urandom_range(9, 0))
                    0: run_s = 31'($urandom);
                    1: run_s = run_s - 31'($urandom_range(4096, 1));
                    default: run_s = run_s + 31'($urandom_range(4096, 0));
                endcase

                push_sample(run_s, px, py, fresh, EXP_MODEL, '0);
                sent++;
            end
        end

        drain_results();
        if (bad_beats == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
